// ----- rtl/core/tqpvm_pkg.sv -----
// ----------------------------------------------------------------------------
// tqpvm_pkg: shared types and constants of the polar vertex mapper
// Payload records of the division and rotation chains, the arctangent table
// and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package tqpvm_pkg;

  // Default sizes of the angle fraction and of the rotation chain.
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 24;

  // Field widths.
  localparam int CX_W   = 17;
  localparam int RAD_W  = 13;
  localparam int PH_W   = 32;
  localparam int ROT_W  = 34;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_WORLD_WIDTH = 2'd0,
    REG_CENTER_X    = 2'd1,
    REG_CENTER_Y    = 2'd2,
    REG_BLOCK_SCALE = 2'd3
  } reg_idx_t;

  localparam logic [16:0] WORLD_WIDTH_RST = 17'd256;
  localparam logic [8:0]  BLOCK_SCALE_RST = 9'd16;

  // Start vector length: the inverse of the rotation gain in Q4.30.
  localparam logic signed [ROT_W-1:0] GAIN_Q30 = 34'sd652032874;

  // One corner while its phase is being divided out.
  typedef struct packed {
    logic [CX_W-1:0]  cx;
    logic [RAD_W-1:0] rad;
    logic [1:0]       corner;
    logic [CX_W-1:0]  rem;
    logic [PH_W-1:0]  phase;
  } div_t;

  // One corner while it is being rotated.
  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
    logic [RAD_W-1:0]        rad;
    logic [1:0]              corner;
  } rot_t;

  // Arctangent of 2^-idx in units of 2^-32 turn.
  function automatic logic signed [ROT_W-1:0] atan_turn(input int idx);
    logic signed [ROT_W-1:0] a;
    case (idx)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10679838;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/core/tqpvm_tile_if.sv -----
// ----------------------------------------------------------------------------
// tqpvm_tile_if: tile request channel
// Carries one tile: its column, its row and its block kind.
// ----------------------------------------------------------------------------
interface tqpvm_tile_if;
  logic        valid;
  logic        ready;
  logic [15:0] tile_x;
  logic [11:0] tile_y;
  logic [7:0]  block_id;

  modport source (output valid, tile_x, tile_y, block_id, input ready);
  modport sink   (input valid, tile_x, tile_y, block_id, output ready);
endinterface

// ----- rtl/core/tqpvm_vertex_if.sv -----
// ----------------------------------------------------------------------------
// tqpvm_vertex_if: vertex result channel
// Carries one screen vertex in Q24.8 with its corner code.
// ----------------------------------------------------------------------------
interface tqpvm_vertex_if;
  logic        valid;
  logic        ready;
  logic [31:0] vertex_x;
  logic [31:0] vertex_y;
  logic [1:0]  corner;
  logic        last_vertex;

  modport source (output valid, vertex_x, vertex_y, corner, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, corner, last_vertex, output ready);
endinterface

// ----- rtl/core/tqpvm_div_cell.sv -----
// ----------------------------------------------------------------------------
// tqpvm_div_cell: one restoring division step
// Shifts one bit into the remainder and subtracts the width when it fits.
// Modulo cells take the bit from the column; fraction cells shift in zero
// and record the quotient bit in the phase.
// ----------------------------------------------------------------------------
module tqpvm_div_cell #(
  parameter bit IS_MOD = 1'b1,
  parameter int BIT    = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [16:0]    width,
  input  logic           v_in,
  input  tqpvm_pkg::div_t d_in,
  output logic           v_out,
  output tqpvm_pkg::div_t d_out
);
  import tqpvm_pkg::*;

  logic        bit_in;
  logic [17:0] shifted;
  logic [17:0] diff;
  logic        ge;
  div_t        d_next;

  // Bit that enters the remainder in this step.
  if (IS_MOD) begin : g_mod
    assign bit_in = d_in.cx[CX_W-1-BIT];
  end else begin : g_frac
    assign bit_in = 1'b0;
  end

  assign shifted = {d_in.rem, bit_in};
  assign diff    = shifted - {1'b0, width};
  assign ge      = (shifted >= {1'b0, width});

  // Restoring step; the remainder stays below the width.
  always_comb begin
    d_next     = d_in;
    d_next.rem = ge ? diff[CX_W-1:0] : shifted[CX_W-1:0];
    if (!IS_MOD) begin
      d_next.phase[PH_W-1-BIT] = ge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end
endmodule

// ----- rtl/core/tqpvm_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// tqpvm_cordic_cell: one rotation step
// Turns the vector by the arctangent of 2^-BIT toward a zero residual angle.
// ----------------------------------------------------------------------------
module tqpvm_cordic_cell #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           v_in,
  input  tqpvm_pkg::rot_t d_in,
  output logic           v_out,
  output tqpvm_pkg::rot_t d_out
);
  import tqpvm_pkg::*;

  localparam logic signed [ROT_W-1:0] ATAN = atan_turn(BIT);

  logic signed [ROT_W-1:0] dx;
  logic signed [ROT_W-1:0] dy;
  rot_t                    d_next;

  // Floor shifts of the cross terms.
  assign dx = d_in.y >>> BIT;
  assign dy = d_in.x >>> BIT;

  always_comb begin
    d_next = d_in;
    if (!d_in.z[ROT_W-1]) begin
      d_next.x = d_in.x - dx;
      d_next.y = d_in.y + dy;
      d_next.z = d_in.z - ATAN;
    end else begin
      d_next.x = d_in.x + dx;
      d_next.y = d_in.y - dy;
      d_next.z = d_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end
endmodule

// ----- rtl/core/tqpvm_scale.sv -----
// ----------------------------------------------------------------------------
// tqpvm_scale: radius, center and block scale
// Three registered steps: radius product, center add with scale product,
// then rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module tqpvm_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic signed [15:0]  center_x,
  input  logic signed [15:0]  center_y,
  input  logic [8:0]          block_scale,
  input  logic                v_in,
  input  tqpvm_pkg::rot_t      d_in,
  tqpvm_vertex_if.source      vertex
);
  import tqpvm_pkg::*;

  logic                v1, v2;
  logic signed [47:0]  px, py;
  logic [1:0]          cor1, cor2;
  logic signed [57:0]  sx, sy;
  logic signed [47:0]  ax, ay;
  logic signed [57:0]  rx, ry;
  logic signed [35:0]  qx, qy;

  // Center in Q18.30 added to the radius product.
  assign ax = px + ({{2{center_x[15]}}, center_x, 30'd0});
  assign ay = py + ({{2{center_y[15]}}, center_y, 30'd0});

  // Round half up, then floor shift.
  assign rx = sx + 58'sd2097152;
  assign ry = sy + 58'sd2097152;
  assign qx = rx[57:22];
  assign qy = ry[57:22];

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
      r = v[31:0];
    end else if (v[35]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      vertex.valid <= 1'b0;
    end else if (en) begin
      v1           <= v_in;
      v2           <= v1;
      vertex.valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px                 <= 48'($signed({1'b0, d_in.rad}) * d_in.x);
      py                 <= 48'($signed({1'b0, d_in.rad}) * d_in.y);
      cor1               <= d_in.corner;
      sx                 <= 58'(ax * $signed({1'b0, block_scale}));
      sy                 <= 58'(ay * $signed({1'b0, block_scale}));
      cor2               <= cor1;
      vertex.vertex_x    <= sat32(qx);
      vertex.vertex_y    <= sat32(qy);
      vertex.corner      <= cor2;
      vertex.last_vertex <= (cor2 == 2'd3);
    end
  end
endmodule

// ----- rtl/core/tile_quad_polar_vertex_mapper.sv -----
// ----------------------------------------------------------------------------
// tile_quad_polar_vertex_mapper: polar vertex mapper for one world tile
//
//   channel  dir  handshake     payload
//   tile     in   valid/ready   tile_x, tile_y, block_id
//   vertex   out  valid/ready   vertex_x, vertex_y, corner, last_vertex
//   cfg      in   cfg_we        cfg_index, cfg_data
//
// A solid tile yields four corners, which the corner sequencer feeds into
// the cell chain one corner a cycle while the vertex output is not stalled.
// An empty tile yields no corners. Reset is synchronous and clears the valid
// bits, the sequencer state and the configuration registers.
// A stalled vertex output holds the whole chain in place.
// ----------------------------------------------------------------------------
module tile_quad_polar_vertex_mapper #(
  parameter int ANGLE_BITS    = tqpvm_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = tqpvm_pkg::CORDIC_STAGES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data,
  tqpvm_tile_if.sink   tile,
  tqpvm_vertex_if.source vertex
);
  import tqpvm_pkg::*;

  localparam int DIV_N = CX_W + ANGLE_BITS;

  // Configuration registers.
  logic [16:0]        world_width;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [8:0]         block_scale;
  logic [16:0]        width_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      world_width <= WORLD_WIDTH_RST;
      center_x    <= '0;
      center_y    <= '0;
      block_scale <= BLOCK_SCALE_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WORLD_WIDTH: world_width <= cfg_data;
        REG_CENTER_X:    center_x    <= cfg_data[15:0];
        REG_CENTER_Y:    center_y    <= cfg_data[15:0];
        REG_BLOCK_SCALE: block_scale <= cfg_data[8:0];
      endcase
    end
  end

  assign width_eff = (world_width == '0) ? 17'd1 : world_width;

  // Whole chain moves unless a finished vertex waits.
  logic en;
  assign en = !vertex.valid || vertex.ready;

  // Corner sequencer.
  logic        busy;
  logic [1:0]  cnt;
  logic [15:0] tx;
  logic [11:0] ty;
  logic        accept;

  assign tile.ready = en && (!busy || cnt == 2'd3);
  assign accept     = tile.valid && tile.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (en) begin
      if (accept && tile.block_id != 8'd0) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx <= tile.tile_x;
      ty <= tile.tile_y;
    end
  end

  // Division chain: column mod width, then the turn fraction.
  div_t dd [0:DIV_N];
  logic dv [0:DIV_N];

  always_comb begin
    dd[0].cx     = {1'b0, tx} + {16'd0, cnt[1]};
    dd[0].rad    = {1'b0, ty} + {12'd0, cnt[0]};
    dd[0].corner = cnt;
    dd[0].rem    = '0;
    dd[0].phase  = '0;
  end
  assign dv[0] = busy;

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    tqpvm_div_cell #(
      .IS_MOD (j < CX_W),
      .BIT    ((j < CX_W) ? j : j - CX_W)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .width (width_eff),
      .v_in  (dv[j]),
      .d_in  (dd[j]),
      .v_out (dv[j+1]),
      .d_out (dd[j+1])
    );
  end

  // Quadrant pre-rotation of the start vector.
  logic [31:0] phase;
  logic [1:0]  quad;
  logic [31:0] zq;
  rot_t        pre_next;
  rot_t        rd [0:CORDIC_STAGES];
  logic        rv [0:CORDIC_STAGES];

  assign phase = dd[DIV_N].phase;
  assign quad  = phase[31:30] + {1'b0, phase[29]};
  assign zq    = {phase[31:30] - quad, phase[29:0]};

  always_comb begin
    pre_next.z      = {{2{zq[31]}}, zq};
    pre_next.rad    = dd[DIV_N].rad;
    pre_next.corner = dd[DIV_N].corner;
    unique case (quad)
      2'd0: begin pre_next.x = GAIN_Q30;  pre_next.y = '0;        end
      2'd1: begin pre_next.x = '0;        pre_next.y = GAIN_Q30;  end
      2'd2: begin pre_next.x = -GAIN_Q30; pre_next.y = '0;        end
      2'd3: begin pre_next.x = '0;        pre_next.y = -GAIN_Q30; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (en) begin
      rv[0] <= dv[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd[0] <= pre_next;
    end
  end

  // Rotation chain.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    tqpvm_cordic_cell #(
      .BIT (i)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .v_in  (rv[i]),
      .d_in  (rd[i]),
      .v_out (rv[i+1]),
      .d_out (rd[i+1])
    );
  end

  // Scale, round and saturate into the output register.
  tqpvm_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .center_x    (center_x),
    .center_y    (center_y),
    .block_scale (block_scale),
    .v_in        (rv[CORDIC_STAGES]),
    .d_in        (rd[CORDIC_STAGES]),
    .vertex      (vertex)
  );

`ifndef SYNTHESIS
  // A tile is never taken while the chain is held.
  a_ready_en: assert property (@(posedge clk) disable iff (rst)
    tile.ready |-> en) else $error("tile taken during stall");

  // The last flag marks exactly the fourth corner.
  a_last: assert property (@(posedge clk) disable iff (rst)
    vertex.valid |-> (vertex.last_vertex == (vertex.corner == 2'd3)))
    else $error("last flag off its corner");

  // The sequencer stays busy until its fourth corner has left.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (busy && en && cnt != 2'd3) |=> (busy && cnt == $past(cnt) + 2'd1))
    else $error("corner sequence broken");
`endif
endmodule
